// File: hdl/rbst_pkg.sv
// Shared constants and types for the ray/box slab test block.
package rbst_pkg;

  localparam int NUM_AXES   = 3;
  localparam int CFG_ADDR_W = 3;

  // Configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_T_LOWER  = 3'd6,
    REG_T_UPPER  = 3'd7
  } cfg_reg_t;

endpackage

// File: hdl/rbst_div.sv
// Pipelined fixed-point divider: (num << FRAC_BITS) / dir, truncated and saturated.
module rbst_div #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic [COORD_BITS+1:0]        stage_en,
  input  logic signed [COORD_BITS:0]   num,
  input  logic signed [COORD_BITS-1:0] dir,
  output logic signed [COORD_BITS-1:0] quo
);

  localparam int C  = COORD_BITS;
  localparam int NW = COORD_BITS + 1 + FRAC_BITS;
  localparam int HW = (FRAC_BITS > COORD_BITS) ? FRAC_BITS + 1 : COORD_BITS + 1;

  logic [C:0]    num_abs;
  logic [C-1:0]  ud;
  logic [NW-1:0] n_full;
  logic [HW-1:0] hi;

  logic [C-1:0] rem_r [0:C];
  logic [C-1:0] low_r [0:C-1];
  logic [C-1:0] q_r   [0:C];
  logic         neg_r [0:C];
  logic         ovf_r [0:C];

  logic [C-1:0]        limit;
  logic [C-1:0]        mag;
  logic signed [C-1:0] quo_nxt;
  logic signed [C-1:0] quo_r;

  // divisor magnitude comes straight from the (static) direction register
  assign ud      = dir[C-1] ? C'(-dir) : C'(dir);
  assign num_abs = num[C] ? (C+1)'(-num) : (C+1)'(num);
  assign n_full  = NW'(num_abs) << FRAC_BITS;
  assign hi      = HW'(n_full >> C);

  // setup: upper bits decide overflow, lower C bits shift in one per stage
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      rem_r[0] <= C'(hi);
      low_r[0] <= n_full[C-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= num[C] ^ dir[C-1];
      ovf_r[0] <= (hi >= HW'(ud));
    end
  end

  for (genvar j = 1; j <= C; j++) begin : g_iter
    logic [C:0] r2;
    logic       ge;

    assign r2 = {rem_r[j-1], low_r[j-1][C-1]};
    assign ge = (r2 >= {1'b0, ud});

    always_ff @(posedge clk) begin
      if (stage_en[j]) begin
        rem_r[j] <= ge ? C'(r2 - {1'b0, ud}) : C'(r2);
        q_r[j]   <= {q_r[j-1][C-2:0], ge};
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < C) begin : g_low
      always_ff @(posedge clk) begin
        if (stage_en[j]) begin
          low_r[j] <= low_r[j-1] << 1;
        end
      end
    end
  end

  // saturate to the signed range, then apply the sign
  assign limit   = neg_r[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
  assign mag     = (ovf_r[C] || (q_r[C] > limit)) ? limit : q_r[C];
  assign quo_nxt = neg_r[C] ? C'(-mag) : C'(mag);

  always_ff @(posedge clk) begin
    if (stage_en[C+1]) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

// File: hdl/rbst_lane.sv
// One axis lane: slab offsets, entry/exit distances, zero-direction handling.
module rbst_lane #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic [COORD_BITS+2:0]        stage_en,
  input  logic signed [COORD_BITS-1:0] bmin,
  input  logic signed [COORD_BITS-1:0] bmax,
  input  logic signed [COORD_BITS-1:0] org,
  input  logic signed [COORD_BITS-1:0] dir,
  output logic signed [COORD_BITS-1:0] t_near,
  output logic signed [COORD_BITS-1:0] t_far,
  output logic                         miss
);

  localparam int C = COORD_BITS;

  logic signed [C:0]   d0_r;
  logic signed [C:0]   d1_r;
  logic                ins_r [0:C+2];
  logic signed [C-1:0] t0;
  logic signed [C-1:0] t1;
  logic                dir_zero;

  // full-precision differences, no wrap
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d0_r     <= {bmin[C-1], bmin} - {org[C-1], org};
      d1_r     <= {bmax[C-1], bmax} - {org[C-1], org};
      ins_r[0] <= !((org < bmin) || (org > bmax));
    end
  end

  for (genvar k = 1; k <= C + 2; k++) begin : g_ins
    always_ff @(posedge clk) begin
      if (stage_en[k]) begin
        ins_r[k] <= ins_r[k-1];
      end
    end
  end

  rbst_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_min (
    .clk     (clk),
    .stage_en(stage_en[C+2:1]),
    .num     (d0_r),
    .dir     (dir),
    .quo     (t0)
  );

  rbst_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_max (
    .clk     (clk),
    .stage_en(stage_en[C+2:1]),
    .num     (d1_r),
    .dir     (dir),
    .quo     (t1)
  );

  assign dir_zero = (dir == '0);

  // zero direction: neutral limits, miss only when origin is outside the slab
  always_comb begin
    if (dir_zero) begin
      t_near = {1'b1, {(C-1){1'b0}}};
      t_far  = {1'b0, {(C-1){1'b1}}};
    end else if (dir[C-1]) begin
      t_near = t1;
      t_far  = t0;
    end else begin
      t_near = t0;
      t_far  = t1;
    end
  end

  assign miss = dir_zero && !ins_r[C+2];

endmodule

// File: hdl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
//
// Usage:
//   The ray (origin, direction, t_lower, t_upper) sits in eight config
//   registers written through cfg_wr_en / cfg_addr / cfg_wdata, one write
//   per cycle, no read-back. Write them only while no item is in flight.
//   Each input item is one box (min and max corner, signed Q16.16) taken on
//   in_valid && !in_stall. Each item yields exactly one result item:
//   out_is_hit and out_t_hit (entry distance, 0 on a miss), taken on
//   out_valid && !out_stall.
// Timing:
//   One item per cycle sustained while out_stall is low. Each item passes
//   through the one-bit-per-stage divider pipelines: three axis lanes, two
//   dividers each, all running in parallel, followed by a two-stage min/max
//   merge and the output register.
// Flow control:
//   Every stage keeps its own valid bit and advances when the stage ahead is
//   empty or moving, so a stalled output only backs up the pipeline once all
//   stages are full; in_stall rises only then.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and returns the
//   registers to origin 0, direction 0, t_lower 0, t_upper max positive.
module ray_box_slab_test #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // box input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_box_min_x,
  input  logic signed [COORD_BITS-1:0]        in_box_min_y,
  input  logic signed [COORD_BITS-1:0]        in_box_min_z,
  input  logic signed [COORD_BITS-1:0]        in_box_max_x,
  input  logic signed [COORD_BITS-1:0]        in_box_max_y,
  input  logic signed [COORD_BITS-1:0]        in_box_max_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_hit,
  output logic signed [COORD_BITS-1:0]        out_t_hit,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [rbst_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [COORD_BITS-1:0]               cfg_wdata
);

  localparam int C  = COORD_BITS;
  localparam int NA = rbst_pkg::NUM_AXES;
  // lane stages (C+3), two merge stages, output register
  localparam int L  = COORD_BITS + 6;
  localparam int M1 = COORD_BITS + 3;
  localparam int M2 = COORD_BITS + 4;
  localparam int SO = COORD_BITS + 5;

  localparam logic signed [C-1:0] T_MAX = {1'b0, {(C-1){1'b1}}};

  // ---------------- configuration registers ----------------
  logic signed [C-1:0] origin_r [NA];
  logic signed [C-1:0] dir_r    [NA];
  logic signed [C-1:0] t_lower_r;
  logic signed [C-1:0] t_upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        origin_r[a] <= '0;
        dir_r[a]    <= '0;
      end
      t_lower_r <= '0;
      t_upper_r <= T_MAX;
    end else if (cfg_wr_en) begin
      unique case (rbst_pkg::cfg_reg_t'(cfg_addr))
        rbst_pkg::REG_ORIGIN_X: origin_r[0] <= cfg_wdata;
        rbst_pkg::REG_ORIGIN_Y: origin_r[1] <= cfg_wdata;
        rbst_pkg::REG_ORIGIN_Z: origin_r[2] <= cfg_wdata;
        rbst_pkg::REG_DIR_X:    dir_r[0]    <= cfg_wdata;
        rbst_pkg::REG_DIR_Y:    dir_r[1]    <= cfg_wdata;
        rbst_pkg::REG_DIR_Z:    dir_r[2]    <= cfg_wdata;
        rbst_pkg::REG_T_LOWER:  t_lower_r   <= cfg_wdata;
        rbst_pkg::REG_T_UPPER:  t_upper_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [L-1:0] v_r;
  logic [L-1:0] v_nxt;
  logic [L-1:0] adv;

  // a stage moves when it is empty or the stage ahead moves
  always_comb begin
    adv[L-1] = !v_r[L-1] || !out_stall;
    for (int k = L - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < L; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !adv[0];

  // ---------------- axis lanes ----------------
  logic signed [C-1:0] bmin_a [NA];
  logic signed [C-1:0] bmax_a [NA];
  logic signed [C-1:0] near_a [NA];
  logic signed [C-1:0] far_a  [NA];
  logic [NA-1:0]       miss_a;

  assign bmin_a[0] = in_box_min_x;
  assign bmin_a[1] = in_box_min_y;
  assign bmin_a[2] = in_box_min_z;
  assign bmax_a[0] = in_box_max_x;
  assign bmax_a[1] = in_box_max_y;
  assign bmax_a[2] = in_box_max_z;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbst_lane #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .stage_en(adv[C+2:0]),
      .bmin    (bmin_a[a]),
      .bmax    (bmax_a[a]),
      .org     (origin_r[a]),
      .dir     (dir_r[a]),
      .t_near  (near_a[a]),
      .t_far   (far_a[a]),
      .miss    (miss_a[a])
    );
  end

  // ---------------- merge: interval narrowing ----------------
  logic signed [C-1:0] lo_a_nxt, lo_b_nxt, hi_a_nxt, hi_b_nxt;
  logic signed [C-1:0] lo_a_r, lo_b_r, hi_a_r, hi_b_r;
  logic                miss1_r;
  logic signed [C-1:0] lo_nxt, hi_nxt;
  logic signed [C-1:0] lo_r, hi_r;
  logic                miss2_r;
  logic                hit_nxt;
  logic                hit_r;
  logic signed [C-1:0] t_hit_r;

  assign lo_a_nxt = (near_a[0] > t_lower_r) ? near_a[0] : t_lower_r;
  assign lo_b_nxt = (near_a[2] > near_a[1]) ? near_a[2] : near_a[1];
  assign hi_a_nxt = (far_a[0] < t_upper_r) ? far_a[0] : t_upper_r;
  assign hi_b_nxt = (far_a[2] < far_a[1]) ? far_a[2] : far_a[1];

  always_ff @(posedge clk) begin
    if (adv[M1]) begin
      lo_a_r  <= lo_a_nxt;
      lo_b_r  <= lo_b_nxt;
      hi_a_r  <= hi_a_nxt;
      hi_b_r  <= hi_b_nxt;
      miss1_r <= |miss_a;
    end
  end

  assign lo_nxt = (lo_b_r > lo_a_r) ? lo_b_r : lo_a_r;
  assign hi_nxt = (hi_b_r < hi_a_r) ? hi_b_r : hi_a_r;

  always_ff @(posedge clk) begin
    if (adv[M2]) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      miss2_r <= miss1_r;
    end
  end

  // interval only shrinks, so one final emptiness check suffices
  assign hit_nxt = !miss2_r && (hi_r >= lo_r);

  always_ff @(posedge clk) begin
    if (adv[SO]) begin
      hit_r   <= hit_nxt;
      t_hit_r <= hit_nxt ? lo_r : '0;
    end
  end

  assign out_valid  = v_r[SO];
  assign out_is_hit = hit_r;
  assign out_t_hit  = t_hit_r;

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled while the pipeline has a free stage");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
      + int'($past(in_valid && !in_stall)) - int'($past(out_valid && !out_stall))))
    else $error("items lost or duplicated in the pipeline");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_hit) |-> (out_t_hit == '0))
    else $error("miss reported with nonzero entry distance");

endmodule
